/* design/psd_pkg.sv */
// Shared constants, types and codes for the packet audio shift decoder.
package psd_pkg;

  localparam int PAIRS_PER_PACKET = 1024;
  localparam int TOTAL_SAMPLES    = 2 * PAIRS_PER_PACKET;
  localparam int SD_W             = $clog2(TOTAL_SAMPLES + 1);

  localparam logic [7:0] ESCAPE_CODE = 8'h80;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    HDR_LEN_HI,
    HDR_LEN_LO,
    HDR_BODY
  } hdr_t;

  typedef enum logic [1:0] {
    PH_SHIFT,
    PH_CODE,
    PH_ESC_HI,
    PH_ESC_LO
  } phase_t;

  typedef struct packed {
    logic       raw;
    logic [7:0] code;
    logic [7:0] esc_high;
    logic [3:0] shift;
    logic       right;
    logic       last;
  } op_t;

endpackage

/* design/psd_front.sv */
// Front end: parses packet headers and body bytes, emits one decode op per sample.
module psd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_data_byte,
  input  logic          q_full,
  output logic          op_push,
  output psd_pkg::op_t  op
);

  psd_pkg::hdr_t            hdr_r, hdr_nxt;
  psd_pkg::phase_t          phase_r, phase_nxt;
  logic [7:0]               len_hi_r, len_hi_nxt;
  logic [15:0]              rem_r, rem_nxt;
  logic [3:0]               lsh_r, lsh_nxt;
  logic [3:0]               rsh_r, rsh_nxt;
  logic [7:0]               esc_r, esc_nxt;
  logic [psd_pkg::SD_W-1:0] sd_r, sd_nxt;

  logic                     accept;
  logic                     body_beat;
  logic                     sample_slot;
  logic                     have;
  logic                     pkt_end;
  logic [15:0]              rem_dec;
  logic [15:0]              new_len;
  logic [psd_pkg::SD_W-1:0] sd_inc;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // classify the beat
  always_comb begin
    rem_dec     = rem_r - 16'd1;
    new_len     = {len_hi_r, in_data_byte};
    sd_inc      = sd_r + {{(psd_pkg::SD_W-1){1'b0}}, 1'b1};
    body_beat   = accept && (hdr_r == psd_pkg::HDR_BODY);
    sample_slot = (phase_r != psd_pkg::PH_SHIFT) &&
                  (sd_r < psd_pkg::SD_W'(psd_pkg::TOTAL_SAMPLES));
    have        = body_beat && sample_slot &&
                  (((phase_r == psd_pkg::PH_CODE) && (in_data_byte != psd_pkg::ESCAPE_CODE)) ||
                   (phase_r == psd_pkg::PH_ESC_LO));
    pkt_end     = body_beat && (rem_dec == 16'd0);
  end

  // next state
  always_comb begin
    hdr_nxt    = hdr_r;
    phase_nxt  = phase_r;
    len_hi_nxt = len_hi_r;
    rem_nxt    = rem_r;
    lsh_nxt    = lsh_r;
    rsh_nxt    = rsh_r;
    esc_nxt    = esc_r;
    sd_nxt     = sd_r;
    if (accept) begin
      unique case (hdr_r)
        psd_pkg::HDR_LEN_HI: begin
          len_hi_nxt = in_data_byte;
          hdr_nxt    = psd_pkg::HDR_LEN_LO;
        end
        psd_pkg::HDR_LEN_LO: begin
          rem_nxt   = new_len;
          phase_nxt = psd_pkg::PH_SHIFT;
          sd_nxt    = '0;
          // empty body: packet is over already
          hdr_nxt   = (new_len == 16'd0) ? psd_pkg::HDR_LEN_HI : psd_pkg::HDR_BODY;
        end
        psd_pkg::HDR_BODY: begin
          rem_nxt = rem_dec;
          if (phase_r == psd_pkg::PH_SHIFT) begin
            lsh_nxt   = in_data_byte[7:4];
            rsh_nxt   = in_data_byte[3:0];
            phase_nxt = psd_pkg::PH_CODE;
          end else if (sample_slot) begin
            unique case (phase_r)
              psd_pkg::PH_CODE: begin
                if (in_data_byte == psd_pkg::ESCAPE_CODE) begin
                  phase_nxt = psd_pkg::PH_ESC_HI;
                end
              end
              psd_pkg::PH_ESC_HI: begin
                esc_nxt   = in_data_byte;
                phase_nxt = psd_pkg::PH_ESC_LO;
              end
              psd_pkg::PH_ESC_LO: begin
                phase_nxt = psd_pkg::PH_CODE;
              end
              psd_pkg::PH_SHIFT: begin
                phase_nxt = phase_r;
              end
            endcase
          end
          if (have) begin
            sd_nxt = sd_inc;
          end
          // body exhausted: drop any partial escape, restart on a new length
          if (pkt_end) begin
            hdr_nxt   = psd_pkg::HDR_LEN_HI;
            phase_nxt = psd_pkg::PH_SHIFT;
            sd_nxt    = '0;
          end
        end
        default: begin
          hdr_nxt = psd_pkg::HDR_LEN_HI;
        end
      endcase
    end
  end

  // op to the back end
  always_comb begin
    op_push     = have;
    op.raw      = (phase_r == psd_pkg::PH_ESC_LO);
    op.code     = in_data_byte;
    op.esc_high = esc_r;
    op.shift    = sd_r[0] ? rsh_r : lsh_r;
    op.right    = sd_r[0];
    op.last     = (sd_inc == psd_pkg::SD_W'(psd_pkg::TOTAL_SAMPLES)) || pkt_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r    <= psd_pkg::HDR_LEN_HI;
      phase_r  <= psd_pkg::PH_SHIFT;
      len_hi_r <= '0;
      rem_r    <= '0;
      lsh_r    <= '0;
      rsh_r    <= '0;
      esc_r    <= '0;
      sd_r     <= '0;
    end else begin
      hdr_r    <= hdr_nxt;
      phase_r  <= phase_nxt;
      len_hi_r <= len_hi_nxt;
      rem_r    <= rem_nxt;
      lsh_r    <= lsh_nxt;
      rsh_r    <= rsh_nxt;
      esc_r    <= esc_nxt;
      sd_r     <= sd_nxt;
    end
  end

endmodule

/* design/psd_queue.sv */
// Small op queue between the front and back ends.
module psd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  psd_pkg::op_t  push_op,
  input  logic          pop,
  output psd_pkg::op_t  head_op,
  output logic          empty,
  output logic          full
);

  psd_pkg::op_t             mem [psd_pkg::Q_DEPTH];
  logic [psd_pkg::Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [psd_pkg::Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [psd_pkg::Q_CW-1:0] count_r, count_nxt;
  logic                     do_push;
  logic                     do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == psd_pkg::Q_CW'(psd_pkg::Q_DEPTH));
  assign head_op = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + {{(psd_pkg::Q_AW-1){1'b0}}, 1'b1} : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + {{(psd_pkg::Q_AW-1){1'b0}}, 1'b1} : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + {{(psd_pkg::Q_CW-1){1'b0}}, 1'b1};
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - {{(psd_pkg::Q_CW-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* design/psd_back.sv */
// Back end: turns decode ops into samples and holds the output register.
module psd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  psd_pkg::op_t  head_op,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [15:0]   out_sample,
  output logic          out_right_channel,
  output logic          out_last_of_packet
);

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] sample_r;
  logic        right_r;
  logic        last_r;
  logic [15:0] code_ext;
  logic [15:0] value;

  assign q_pop = !q_empty && (!out_valid_r || !out_stall);

  always_comb begin
    code_ext = {{8{head_op.code[7]}}, head_op.code};
    value    = head_op.raw ? {head_op.esc_high, head_op.code} : (code_ext << head_op.shift);
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // load the beat only when the slot is free or being taken
  always_ff @(posedge clk) begin
    if (q_pop) begin
      sample_r <= value;
      right_r  <= head_op.right;
      last_r   <= head_op.last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sample         = sample_r;
  assign out_right_channel  = right_r;
  assign out_last_of_packet = last_r;

endmodule

/* design/packet_audio_shift_decoder.sv */
// Top level of the packet audio shift decoder.
// Input channel: one packet stream byte per beat (in_valid / in_stall / in_data_byte).
// Each packet is a 2-byte big-endian body length, a shift byte (left nibble high,
// right nibble low), then left/right codes; 0x80 escapes a raw big-endian sample.
// Output channel: one decoded 16-bit sample per beat, with its channel and a flag
// on the last sample of the packet (out_valid / out_stall / out_*).
// Throughput: one byte per cycle sustained while the op queue is not full; header,
// shift and escape-prefix bytes produce no sample. The byte completing a sample is
// written into the op queue at the edge that accepts it, then into the output
// register, which raises out_valid for the beat.
// The front end parses bytes into decode ops, a 4-entry op queue decouples it
// from the back end, which forms the sample and holds it in the output register.
// A stalled receiver holds the output beat; the queue then fills and in_stall
// rises once it is full, never combinationally from out_stall.
// Reset (rst_n low, synchronous) empties the queue and output register and
// returns the parser to expect a new packet length.
module packet_audio_shift_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  output logic               out_right_channel,
  output logic               out_last_of_packet
);

  psd_pkg::op_t push_op;
  psd_pkg::op_t head_op;
  logic         op_push;
  logic         q_pop;
  logic         q_empty;
  logic         q_full;
  logic [15:0]  sample;

  psd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .op_push      (op_push),
    .op           (push_op)
  );

  psd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (op_push),
    .push_op (push_op),
    .pop     (q_pop),
    .head_op (head_op),
    .empty   (q_empty),
    .full    (q_full)
  );

  psd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .head_op            (head_op),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_sample         (sample),
    .out_right_channel  (out_right_channel),
    .out_last_of_packet (out_last_of_packet)
  );

  assign out_sample = $signed(sample);

endmodule

/* design/psd_checker.sv */
// Port-level assertions for the packet audio shift decoder, bound to the top level.
module psd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [7:0]         in_data_byte,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_sample,
  input logic               out_right_channel,
  input logic               out_last_of_packet
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample) &&
    $stable(out_right_channel) && $stable(out_last_of_packet))
    else $error("output beat changed under stall");

  // stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data_byte))
    else $error("input beat changed under stall");

  // output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a fresh output beat follows an accepted byte through the queue and output register
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("output beat without a preceding input beat");

  // the input side never stalls while the output side is idle and empty
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !$past(out_valid) && !$past(in_valid) |-> !in_stall)
    else $error("input stalled with nothing in flight");

endmodule

bind packet_audio_shift_decoder psd_checker u_psd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_data_byte       (in_data_byte),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_sample         (out_sample),
  .out_right_channel  (out_right_channel),
  .out_last_of_packet (out_last_of_packet)
);

/* bench/psd_sample_checker.sv */
// Sample checker: watches both channels, predicts decoded samples and compares them.
`timescale 1ns / 100ps

module psd_sample_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_sample,
  input  logic               out_right_channel,
  input  logic               out_last_of_packet,
  output int                 mismatches,
  output int                 expected_left
);

  typedef struct packed {
    logic signed [15:0] sample;
    logic               right;
    logic               last;
  } sample_exp_t;

  sample_exp_t sample_q[$];

  // Decoder state mirrored from the block
  psd_pkg::hdr_t            hdr_state;
  logic [15:0]              body_len;
  logic [15:0]              body_left;
  logic [3:0]               left_shift;
  logic [3:0]               right_shift;
  psd_pkg::phase_t          code_phase;
  logic [7:0]               esc_high;
  logic [psd_pkg::SD_W-1:0] samples_done;

  task automatic report_mismatch(input string msg);
    $display("t=%0t %s", $time, msg);
    mismatches++;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic        have;
    logic        chan;
    logic        last;
    logic [15:0] val;
    logic [15:0] wide;
    sample_exp_t exp_s;
    have = 1'b0;
    chan = 1'b0;
    val  = '0;
    if (hdr_state == psd_pkg::HDR_LEN_HI) begin
      body_len  = {b, 8'h00};
      hdr_state = psd_pkg::HDR_LEN_LO;
    end else if (hdr_state == psd_pkg::HDR_LEN_LO) begin
      body_len[7:0] = b;
      body_left     = body_len;
      code_phase    = psd_pkg::PH_SHIFT;
      samples_done  = '0;
      // an empty body closes the packet right away
      hdr_state     = (body_len == 16'd0) ? psd_pkg::HDR_LEN_HI : psd_pkg::HDR_BODY;
    end else begin
      body_left = body_left - 16'd1;
      if (code_phase == psd_pkg::PH_SHIFT) begin
        left_shift  = b[7:4];
        right_shift = b[3:0];
        code_phase  = psd_pkg::PH_CODE;
      end else if (samples_done < psd_pkg::SD_W'(psd_pkg::TOTAL_SAMPLES)) begin
        chan = samples_done[0];
        case (code_phase)
          psd_pkg::PH_CODE: begin
            if (b == psd_pkg::ESCAPE_CODE) begin
              code_phase = psd_pkg::PH_ESC_HI;
            end else begin
              wide = {{8{b[7]}}, b};
              val  = wide << (chan ? right_shift : left_shift);
              have = 1'b1;
            end
          end
          psd_pkg::PH_ESC_HI: begin
            esc_high   = b;
            code_phase = psd_pkg::PH_ESC_LO;
          end
          default: begin
            val        = {esc_high, b};
            code_phase = psd_pkg::PH_CODE;
            have       = 1'b1;
          end
        endcase
      end
      last = 1'b0;
      if (have) begin
        samples_done = samples_done + {{(psd_pkg::SD_W-1){1'b0}}, 1'b1};
        if (samples_done >= psd_pkg::SD_W'(psd_pkg::TOTAL_SAMPLES)) last = 1'b1;
      end
      // body exhausted: close the packet, drop any partial escape
      if (body_left == 16'd0) begin
        last         = have;
        hdr_state    = psd_pkg::HDR_LEN_HI;
        code_phase   = psd_pkg::PH_SHIFT;
        samples_done = '0;
      end
      if (have) begin
        exp_s.sample = val;
        exp_s.right  = chan;
        exp_s.last   = last;
        sample_q.insert(sample_q.size(), exp_s);
      end
    end
  endtask

  always @(posedge clk) begin
    sample_exp_t want;
    if (!rst_n) begin
      hdr_state    = psd_pkg::HDR_LEN_HI;
      body_len     = '0;
      body_left    = '0;
      left_shift   = '0;
      right_shift  = '0;
      code_phase   = psd_pkg::PH_SHIFT;
      esc_high     = '0;
      samples_done = '0;
      mismatches   = 0;
      sample_q.delete();
    end else begin
      // check the output beat first: it can never come from this edge's byte
      if (out_valid && !out_stall) begin
        if (sample_q.size() == 0) begin
          report_mismatch($sformatf("unexpected sample beat %0d", out_sample));
        end else begin
          want = sample_q.pop_front();
          if (out_sample !== want.sample)
            report_mismatch($sformatf("sample %0d, want %0d", out_sample, want.sample));
          if (out_right_channel !== want.right)
            report_mismatch($sformatf("right_channel %b, want %b",
                                      out_right_channel, want.right));
          if (out_last_of_packet !== want.last)
            report_mismatch($sformatf("last_of_packet %b, want %b",
                                      out_last_of_packet, want.last));
        end
      end
      if (in_valid && !in_stall) decode_byte(in_data_byte);
    end
    expected_left = sample_q.size();
  end

endmodule

/* bench/packet_audio_shift_decoder_test.sv */
// Testbench top: drives packet byte streams into the decoder and gives the verdict.
`timescale 1ns / 100ps

module packet_audio_shift_decoder_test;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_data_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_sample;
  logic               out_right_channel;
  logic               out_last_of_packet;

  int mismatches;
  int expected_left;

  int send_pct = 0;
  int recv_pct = 0;
  int hold_tick = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int bytes_sent = 0;

  logic [7:0] body[$];
  logic [7:0] directed_bytes [0:25];

  packet_audio_shift_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample        (out_sample),
    .out_right_channel (out_right_channel),
    .out_last_of_packet(out_last_of_packet)
  );

  psd_sample_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample        (out_sample),
    .out_right_channel (out_right_channel),
    .out_last_of_packet(out_last_of_packet),
    .mismatches        (mismatches),
    .expected_left     (expected_left)
  );

  always #6 clk = ~clk;

  // Receiver: random stalls, or a long hold-off when the stimulus asks for one
  always @(negedge clk) begin
    if (hold_seen != hold_tick) begin
      hold_seen = hold_tick;
      hold_left = 300;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken
  task automatic put_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Append one byte to the body under construction
  task automatic add_body_byte(input logic [7:0] b);
    body.insert(body.size(), b);
  endtask

  // Build a packet body and send it behind its length. A full packet runs to the
  // complete pair count and then appends excess bytes; otherwise the body is cut
  // at cap bytes, which may split an escape.
  task automatic send_packet(input int cap, input bit full, input int excess, input bit noise);
    logic [7:0]  code;
    logic [15:0] len;
    int          samples;
    body.delete();
    add_body_byte(8'($urandom_range(255)));
    samples = 0;
    while (full ? (samples < psd_pkg::TOTAL_SAMPLES) : (body.size() < cap)) begin
      if ($urandom_range(99) < 15) begin
        add_body_byte(psd_pkg::ESCAPE_CODE);
        add_body_byte(8'($urandom_range(255)));
        add_body_byte(8'($urandom_range(255)));
      end else begin
        code = 8'($urandom_range(255));
        if (code == psd_pkg::ESCAPE_CODE) code = ~code;
        add_body_byte(code);
      end
      samples++;
    end
    if (full) begin
      repeat (excess) add_body_byte(8'($urandom_range(255)));
    end else begin
      while (body.size() > cap) code = body.pop_back();
    end
    if (noise) foreach (body[i]) body[i] = 8'($urandom_range(255));
    len = 16'(body.size());
    put_byte(len[15:8]);
    put_byte(len[7:0]);
    foreach (body[i]) put_byte(body[i]);
  endtask

  // Hold the sender until every predicted sample has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_left != 0) @(negedge clk);
  endtask

  initial begin
    int phase_start;
    // zero-length packet, extreme shifts and codes, escape closing the body,
    // partial escapes dropped at body end, shift-only packet
    directed_bytes = '{8'h00, 8'h00,
                       8'h00, 8'h06, 8'hF0, 8'h7F, 8'hFF, 8'h80, 8'h80, 8'h00,
                       8'h00, 8'h05, 8'h0F, 8'h80, 8'h7F, 8'hFF, 8'h80,
                       8'h00, 8'h01, 8'h80,
                       8'h00, 8'h04, 8'h5A, 8'h01, 8'hFF, 8'h80};
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_bytes[i]) put_byte(directed_bytes[i]);
    wait_drained();

    // long receiver hold-off while the sender keeps pushing
    hold_tick++;
    send_packet(60, 1'b0, 0, 1'b0);
    send_packet(40, 1'b0, 0, 1'b0);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 74; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 74; end
        default: begin send_pct = 16; recv_pct = 16; end
      endcase
      // full pair count, with excess body bytes behind the last sample
      if (p == 2) send_packet(0, 1'b1, $urandom_range(1, 12), 1'b0);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 250)
        send_packet($urandom_range(0, 40), 1'b0, 0, $urandom_range(99) < 10);
      wait_drained();
    end

    recv_pct = 0;
    repeat (10) @(negedge clk);
    if (mismatches == 0 && expected_left == 0) begin
      $display("packet_audio_shift_decoder: match");
    end else begin
      $display("packet_audio_shift_decoder: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("packet_audio_shift_decoder: mismatch");
    $finish;
  end

endmodule

/* packet_audio_shift_decoder.f */
design/psd_pkg.sv
design/psd_front.sv
design/psd_queue.sv
design/psd_back.sv
design/packet_audio_shift_decoder.sv
design/psd_checker.sv
bench/psd_sample_checker.sv
bench/packet_audio_shift_decoder_test.sv
